// ===== hdl/srtf_pkg.sv =====
// Shared constants and types of the shortest-remaining-time-first scheduler.
package srtf_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int ID_W      = 16;
	localparam int TU_W      = 12;
	localparam int OUT_W     = 17;
	// Wide enough for the latest completion: every burst after the latest arrival.
	localparam int TIME_W    = $clog2((MAX_PROCS + 1) * 4095 + 1);
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// Static part of a process record, written when it is loaded.
	typedef struct packed {
		logic [TU_W-1:0] burst;
		logic [TU_W-1:0] arrival;
		logic [ID_W-1:0] id;
	} rec_t;

	// Dynamic part, rewritten for the chosen entry at every executed time unit.
	typedef struct packed {
		logic [TIME_W-1:0] finish;
		logic [TU_W-1:0]   rem;
	} dyn_t;

	typedef struct packed {
		logic              start;
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [TU_W-1:0]   arrival;
		logic [TU_W-1:0]   rem;
		logic [TIME_W-1:0] now;
	} pick_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [TU_W-1:0]  rem;
	} pick_out_t;

endpackage

// ===== hdl/srtf_pick.sv =====
// Running minimum search over the table entries streamed out of the memories.
module srtf_pick
	import srtf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pick_in_t  pin,
	output pick_out_t pout
);

	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	logic [TU_W-1:0]  rem_q;
	logic             take;

	// Strict less-than keeps the earliest loaded entry on a tie.
	assign take = pin.valid && (TIME_W'(pin.arrival) <= pin.now) && (pin.rem != '0) &&
		(!found_q || (pin.rem < rem_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (pin.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!pin.start && take) begin
			idx_q <= pin.idx;
			rem_q <= pin.rem;
		end
	end

	assign pout.found = found_q;
	assign pout.idx   = idx_q;
	assign pout.rem   = rem_q;

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (rem_q != '0))
		else $error("picked entry has no remaining time");

	a_rose_on_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(pin.valid))
		else $error("pick set without a candidate");

	a_min_only_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && $past(found_q) && !$past(pin.start)) |-> (rem_q <= $past(rem_q)))
		else $error("running minimum grew during a scan");

endmodule

// ===== hdl/srtf_process_scheduler_core.sv =====
// Top level of the shortest-remaining-time-first scheduler.
// Loading accepts one record transaction per cycle; the record with tlast (or the one
// that fills the table) starts the simulation. Each simulated time unit is made of one
// memory read per loaded entry in the scan, the registered read, the close of the scan
// and the read-modify-write of the chosen entry. Results then leave one at a time; each
// is loaded into the output register only after the sink has taken the previous one.
// arst_n clears the controller, counters and output valid; the tables are not reset.
module srtf_process_scheduler_core
	import srtf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // proc_id[15:0], arrival[27:16], burst[39:28]
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// done_id[15:0], completion[32:16], turnaround[49:33], waiting[66:50], zero[71:67]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	typedef enum logic [4:0] {
		ST_LOAD    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_UPDATE  = 5'b00100,
		ST_EMIT_RD = 5'b01000,
		ST_EMIT_LD = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  fin_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	rec_t rec_mem [MAX_PROCS];
	dyn_t dyn_mem [MAX_PROCS];
	rec_t rec_rd_q;
	dyn_t dyn_rd_q;

	logic             rec_we;
	logic             dyn_we;
	logic [IDX_W-1:0] dyn_addr;
	rec_t             rec_wd;
	dyn_t             dyn_wd;
	logic [IDX_W-1:0] rd_addr;
	logic [TU_W-1:0]  burst_in;
	logic             s_acc;
	logic             load_last;
	logic             issue;
	logic             scan_done;
	logic             emit_last;

	pick_in_t  pin;
	pick_out_t pout;

	logic                out_vld_q;
	logic                out_last_q;
	logic [ID_W-1:0]     out_id_q;
	logic [OUT_W-1:0]    out_cmp_q;
	logic [OUT_W-1:0]    out_tat_q;
	logic [OUT_W-1:0]    out_wt_q;
	logic [TIME_W-1:0]   tat_full;
	logic [TIME_W-1:0]   wt_full;

	assign s_tready  = (state_q == ST_LOAD);
	assign s_acc     = s_tvalid && s_tready;
	assign burst_in  = (s_tdata[39:28] == '0) ? TU_W'(1) : s_tdata[39:28];
	assign load_last = s_tlast || ((cnt_q + CNT_W'(1)) == CNT_W'(MAX_PROCS));
	assign issue     = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !vld_s1;
	assign emit_last = ((idx_q + CNT_W'(1)) == cnt_q);
	assign rd_addr   = idx_q[IDX_W-1:0];

	// Write ports: records are loaded, and the chosen entry is rewritten after a scan.
	assign rec_we      = s_acc;
	assign rec_wd.id      = s_tdata[15:0];
	assign rec_wd.arrival = s_tdata[27:16];
	assign rec_wd.burst   = burst_in;

	always_comb begin
		dyn_we   = 1'b0;
		dyn_addr = cnt_q[IDX_W-1:0];
		dyn_wd.rem    = burst_in;
		dyn_wd.finish = now_q + TIME_W'(1);
		if (s_acc) begin
			dyn_we = 1'b1;
		end else if ((state_q == ST_UPDATE) && pout.found) begin
			dyn_we     = 1'b1;
			dyn_addr   = pout.idx;
			dyn_wd.rem = pout.rem - TU_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[cnt_q[IDX_W-1:0]] <= rec_wd;
		end
		if (dyn_we) begin
			dyn_mem[dyn_addr] <= dyn_wd;
		end
		rec_rd_q <= rec_mem[rd_addr];
		dyn_rd_q <= dyn_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
	end

	assign pin.start   = (state_q == ST_UPDATE) || (s_acc && load_last);
	assign pin.valid   = vld_s1;
	assign pin.idx     = idx_s1;
	assign pin.arrival = rec_rd_q.arrival;
	assign pin.rem     = dyn_rd_q.rem;
	assign pin.now     = now_q;

	srtf_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.pin    (pin),
		.pout   (pout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			fin_q   <= '0;
			idx_q   <= '0;
			now_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (load_last) begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
							now_q   <= '0;
							fin_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					now_q   <= now_q + TIME_W'(1);
					idx_q   <= '0;
					state_q <= ST_SCAN;
					if (pout.found && (pout.rem == TU_W'(1))) begin
						fin_q <= fin_q + CNT_W'(1);
						if ((fin_q + CNT_W'(1)) == cnt_q) begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_RD: begin
					if (!out_vld_q || m_tready) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					idx_q <= idx_q + CNT_W'(1);
					if (emit_last) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						fin_q   <= '0;
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign tat_full = dyn_rd_q.finish - TIME_W'(rec_rd_q.arrival);
	assign wt_full  = tat_full - TIME_W'(rec_rd_q.burst);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_EMIT_LD) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_id_q   <= rec_rd_q.id;
			out_cmp_q  <= dyn_rd_q.finish[OUT_W-1:0];
			out_tat_q  <= tat_full[OUT_W-1:0];
			out_wt_q   <= wt_full[OUT_W-1:0];
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'b0, out_wt_q, out_tat_q, out_cmp_q, out_id_q};

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD) |-> !out_vld_q)
		else $error("result loaded over an untaken transaction");

	a_fin_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q <= cnt_q))
		else $error("more processes finished than loaded");

	a_scan_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((cnt_q != '0) && (idx_q <= cnt_q)))
		else $error("scan over an empty table or past its end");

endmodule
